// File: rtl/slk_pkg.sv
// ----------------------------------------------------------------------------
// slk_pkg
// Shared widths, stage counts and saturation helpers for the slack
// condensing pipeline.
// ----------------------------------------------------------------------------
package slk_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // unsigned field width (positive Q format, sign bit dropped)
  localparam int UW = DATA_WIDTH - 1;

  // dividend is 1.0 * 2^FRAC_BITS = 2^(2*FRAC_BITS); one quotient bit per step
  localparam int DIV_BITS   = 2 * FRAC_BITS + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // residual unit latency and the sideband delay that lines it up with the divider
  localparam int RES_STAGES = 2;
  localparam int SIDE_DLY   = DIV_STAGES - RES_STAGES;

  // extended width for sums of products before saturation
  localparam int EW = 2 * DATA_WIDTH + 2;

  localparam logic signed [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [UW-1:0]                UMAX = {UW{1'b1}};

  // clamp a wide signed value to the signed data range
  function automatic logic signed [DATA_WIDTH-1:0] sat_s(input logic signed [EW-1:0] v);
    logic signed [DATA_WIDTH-1:0] res;
    if (v > EW'(QMAX)) begin
      res = QMAX;
    end else if (v < EW'(QMIN)) begin
      res = QMIN;
    end else begin
      res = v[DATA_WIDTH-1:0];
    end
    return res;
  endfunction

  // clamp a wide unsigned value to the positive range
  function automatic logic [UW-1:0] sat_u(input logic [EW-1:0] v);
    logic [UW-1:0] res;
    if (v > EW'(UMAX)) begin
      res = UMAX;
    end else begin
      res = v[UW-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/slk_recip_div.sv
// ----------------------------------------------------------------------------
// slk_recip_div
// Pipelined restoring divider forming floor(2^(2*FRAC_BITS) / slack),
// up to DIV_STEPS (four) quotient bits per stage, saturated to the positive range.
// ----------------------------------------------------------------------------
module slk_recip_div (
  input  logic                 clk,
  input  logic                 en,
  input  logic [slk_pkg::UW-1:0] slack,
  output logic [slk_pkg::UW-1:0] inv
);

  localparam int DW  = slk_pkg::DATA_WIDTH;
  localparam int UW  = slk_pkg::UW;
  localparam int NST = slk_pkg::DIV_STAGES;
  localparam int NS  = slk_pkg::DIV_STEPS;
  localparam int NB  = slk_pkg::DIV_BITS;

  logic [DW-1:0] rem  [1:NST];
  logic [UW-1:0] quo  [1:NST];
  logic          ovf  [1:NST];
  logic [UW-1:0] dvs  [1:NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [DW-1:0] rin;
    logic [UW-1:0] qin;
    logic          oin;
    logic [UW-1:0] din;
    logic [DW-1:0] r;
    logic [DW-1:0] r2;
    logic [UW-1:0] q;
    logic          o;

    // seed the first stage, chain the rest
    if (k == 0) begin : g_seed
      assign rin = '0;
      assign qin = '0;
      assign oin = 1'b0;
      assign din = slack;
    end else begin : g_chain
      assign rin = rem[k];
      assign qin = quo[k];
      assign oin = ovf[k];
      assign din = dvs[k];
    end

    // run this stage's quotient bits
    always_comb begin
      r  = rin;
      q  = qin;
      o  = oin;
      r2 = '0;
      for (int t = 0; t < NS; t++) begin
        if (k * NS + t < NB) begin
          r2 = {r[DW-2:0], (k * NS + t == 0) ? 1'b1 : 1'b0};
          o  = o | q[UW-1];
          if (r2 >= {1'b0, din}) begin
            r = r2 - {1'b0, din};
            q = {q[UW-2:0], 1'b1};
          end else begin
            r = r2;
            q = {q[UW-2:0], 1'b0};
          end
        end
      end
    end

    // advance the stage
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= r;
        quo[k+1] <= q;
        ovf[k+1] <= o;
        dvs[k+1] <= din;
      end
    end
  end

  // saturate on quotient overflow
  assign inv = ovf[NST] ? slk_pkg::UMAX : quo[NST];

endmodule

// File: rtl/slk_resid.sv
// ----------------------------------------------------------------------------
// slk_resid
// Residual correction: a = sat(rm_l - lam_l*rd_l), b = sat(rm_u + lam_u*rd_u),
// in two stages, with the multipliers and flag carried alongside.
// ----------------------------------------------------------------------------
module slk_resid (
  input  logic                                clk,
  input  logic                                en,
  input  logic [slk_pkg::UW-1:0]              lower_mult,
  input  logic [slk_pkg::UW-1:0]              upper_mult,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] lower_comp_residual,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] upper_comp_residual,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] lower_dual_residual,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] upper_dual_residual,
  input  logic                                last_element,
  output logic [slk_pkg::UW-1:0]              ml,
  output logic [slk_pkg::UW-1:0]              mu,
  output logic signed [slk_pkg::DATA_WIDTH-1:0] res_a,
  output logic signed [slk_pkg::DATA_WIDTH-1:0] res_b,
  output logic                                last
);

  localparam int DW = slk_pkg::DATA_WIDTH;
  localparam int UW = slk_pkg::UW;
  localparam int EW = slk_pkg::EW;
  localparam int FB = slk_pkg::FRAC_BITS;

  logic signed [2*DW-1:0] prod_l;
  logic signed [2*DW-1:0] prod_u;
  logic signed [DW-1:0]   rm_l;
  logic signed [DW-1:0]   rm_u;
  logic [UW-1:0]          ml1;
  logic [UW-1:0]          mu1;
  logic                   last1;
  logic signed [EW-1:0]   sum_a;
  logic signed [EW-1:0]   sum_b;

  // stage 1: multiplier times dual residual
  always_ff @(posedge clk) begin
    if (en) begin
      prod_l <= $signed({1'b0, lower_mult}) * lower_dual_residual;
      prod_u <= $signed({1'b0, upper_mult}) * upper_dual_residual;
      rm_l   <= lower_comp_residual;
      rm_u   <= upper_comp_residual;
      ml1    <= lower_mult;
      mu1    <= upper_mult;
      last1  <= last_element;
    end
  end

  // scale by floor and combine with the complementarity residual
  assign sum_a = EW'(rm_l) - EW'(prod_l >>> FB);
  assign sum_b = EW'(rm_u) + EW'(prod_u >>> FB);

  // stage 2: saturate
  always_ff @(posedge clk) begin
    if (en) begin
      res_a <= slk_pkg::sat_s(sum_a);
      res_b <= slk_pkg::sat_s(sum_b);
      ml    <= ml1;
      mu    <= mu1;
      last  <= last1;
    end
  end

endmodule

// File: rtl/slk_condense.sv
// ----------------------------------------------------------------------------
// slk_condense
// Final two stages: four products with the slack reciprocals, then the
// saturated Hessian diagonal and gradient correction.
// ----------------------------------------------------------------------------
module slk_condense (
  input  logic                                clk,
  input  logic                                en,
  input  logic [slk_pkg::UW-1:0]              inv_l,
  input  logic [slk_pkg::UW-1:0]              inv_u,
  input  logic [slk_pkg::UW-1:0]              ml,
  input  logic [slk_pkg::UW-1:0]              mu,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] res_a,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] res_b,
  input  logic                                last_in,
  output logic [slk_pkg::UW-1:0]              lower_slack_inv,
  output logic [slk_pkg::UW-1:0]              upper_slack_inv,
  output logic [slk_pkg::UW-1:0]              hessian_diag,
  output logic signed [slk_pkg::DATA_WIDTH-1:0] gradient_corr,
  output logic                                last_out
);

  localparam int DW = slk_pkg::DATA_WIDTH;
  localparam int UW = slk_pkg::UW;
  localparam int EW = slk_pkg::EW;
  localparam int FB = slk_pkg::FRAC_BITS;

  logic [2*UW-1:0]        ph_l;
  logic [2*UW-1:0]        ph_u;
  logic signed [2*DW-1:0] pg_l;
  logic signed [2*DW-1:0] pg_u;
  logic [UW-1:0]          inv_l1;
  logic [UW-1:0]          inv_u1;
  logic                   last1;
  logic [EW-1:0]          h_sum;
  logic signed [EW-1:0]   g_sum;

  // stage 1: products with the reciprocals
  always_ff @(posedge clk) begin
    if (en) begin
      ph_l   <= inv_l * ml;
      ph_u   <= inv_u * mu;
      pg_l   <= $signed({1'b0, inv_l}) * res_a;
      pg_u   <= $signed({1'b0, inv_u}) * res_b;
      inv_l1 <= inv_l;
      inv_u1 <= inv_u;
      last1  <= last_in;
    end
  end

  // scale back by floor and combine
  assign h_sum = EW'(ph_l >> FB) + EW'(ph_u >> FB);
  assign g_sum = EW'(pg_l >>> FB) - EW'(pg_u >>> FB);

  // stage 2: saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      lower_slack_inv <= inv_l1;
      upper_slack_inv <= inv_u1;
      hessian_diag    <= slk_pkg::sat_u(h_sum);
      gradient_corr   <= slk_pkg::sat_s(g_sum);
      last_out        <= last1;
    end
  end

endmodule

// File: rtl/ipm_slack_condensing_core.sv
// ----------------------------------------------------------------------------
// ipm_slack_condensing_core
// Box-constraint condensing for an interior-point iteration, one constraint
// per cycle when not stalled.
// ----------------------------------------------------------------------------
// Takes one constraint per clock while the pipeline is not stalled, and returns
// one result per constraint, in order. At Q16.16 the slack reciprocal divider
// retires four quotient bits per stage over 33 bits, and two more stages
// form the products and the saturated sums. The residual corrections run
// beside the divider. The whole pipeline advances when the output register
// is empty or being taken, so a stall holds every stage.
module ipm_slack_condensing_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slk_pkg::UW-1:0]              lower_slack,
  input  logic [slk_pkg::UW-1:0]              upper_slack,
  input  logic [slk_pkg::UW-1:0]              lower_mult,
  input  logic [slk_pkg::UW-1:0]              upper_mult,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] lower_comp_residual,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] upper_comp_residual,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] lower_dual_residual,
  input  logic signed [slk_pkg::DATA_WIDTH-1:0] upper_dual_residual,
  input  logic                                last_element,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [slk_pkg::UW-1:0]              lower_slack_inv,
  output logic [slk_pkg::UW-1:0]              upper_slack_inv,
  output logic [slk_pkg::UW-1:0]              hessian_diag,
  output logic signed [slk_pkg::DATA_WIDTH-1:0] gradient_corr,
  output logic                                last_out
);

  localparam int DW    = slk_pkg::DATA_WIDTH;
  localparam int UW    = slk_pkg::UW;
  localparam int DLY   = slk_pkg::SIDE_DLY;
  localparam int DEPTH = slk_pkg::DIV_STAGES + 2;

  logic                 en;
  logic [DEPTH-1:0]     vld;
  logic [UW-1:0]        inv_l;
  logic [UW-1:0]        inv_u;
  logic [UW-1:0]        r_ml;
  logic [UW-1:0]        r_mu;
  logic signed [DW-1:0] r_a;
  logic signed [DW-1:0] r_b;
  logic                 r_last;
  logic [UW-1:0]        d_ml   [DLY];
  logic [UW-1:0]        d_mu   [DLY];
  logic signed [DW-1:0] d_a    [DLY];
  logic signed [DW-1:0] d_b    [DLY];
  logic                 d_last [DLY];

  // advance everything unless the output holds an untaken result
  assign en        = !vld[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  // track valid bits through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  slk_recip_div u_div_l (
    .clk   (clk),
    .en    (en),
    .slack (lower_slack),
    .inv   (inv_l)
  );

  slk_recip_div u_div_u (
    .clk   (clk),
    .en    (en),
    .slack (upper_slack),
    .inv   (inv_u)
  );

  slk_resid u_resid (
    .clk                 (clk),
    .en                  (en),
    .lower_mult          (lower_mult),
    .upper_mult          (upper_mult),
    .lower_comp_residual (lower_comp_residual),
    .upper_comp_residual (upper_comp_residual),
    .lower_dual_residual (lower_dual_residual),
    .upper_dual_residual (upper_dual_residual),
    .last_element        (last_element),
    .ml                  (r_ml),
    .mu                  (r_mu),
    .res_a               (r_a),
    .res_b               (r_b),
    .last                (r_last)
  );

  // delay the residual side to line up with the divider
  always_ff @(posedge clk) begin
    if (en) begin
      d_ml[0]   <= r_ml;
      d_mu[0]   <= r_mu;
      d_a[0]    <= r_a;
      d_b[0]    <= r_b;
      d_last[0] <= r_last;
      for (int i = 1; i < DLY; i++) begin
        d_ml[i]   <= d_ml[i-1];
        d_mu[i]   <= d_mu[i-1];
        d_a[i]    <= d_a[i-1];
        d_b[i]    <= d_b[i-1];
        d_last[i] <= d_last[i-1];
      end
    end
  end

  slk_condense u_condense (
    .clk             (clk),
    .en              (en),
    .inv_l           (inv_l),
    .inv_u           (inv_u),
    .ml              (d_ml[DLY-1]),
    .mu              (d_mu[DLY-1]),
    .res_a           (d_a[DLY-1]),
    .res_b           (d_b[DLY-1]),
    .last_in         (d_last[DLY-1]),
    .lower_slack_inv (lower_slack_inv),
    .upper_slack_inv (upper_slack_inv),
    .hessian_diag    (hessian_diag),
    .gradient_corr   (gradient_corr),
    .last_out        (last_out)
  );

endmodule
